[hw/rtl/dqs_pkg.sv]
// Shared types, constants and ring helpers for the deque with search.
`default_nettype none
package dqs_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_SEARCH     = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPWAIT,
    S_SEARCH,
    S_EMIT
  } state_t;

  // ring storage access from the sequencer
  typedef struct packed {
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [IDX_W-1:0]         rd_addr;
  } mem_req_t;

  // finished result handed to the output register
  typedef struct packed {
    logic                     valid;
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
  } result_t;

  // (pos + off) mod DEPTH, for pos < DEPTH and off < DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] pos,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(pos) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] pos);
    logic [IDX_W-1:0] r;
    if (pos == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = pos - IDX_W'(1);
    end
    return r;
  endfunction

  // fill count masked to the width of the count field
  function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] fill);
    logic [CNT_W+COUNT_W-1:0] ext;
    ext = {{COUNT_W{1'b0}}, fill};
    return ext[COUNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/dqs_ring.sv]
// Ring storage: one write port, one registered read port.
`default_nettype none
module dqs_ring (
  input  wire logic                             clk,
  input  wire dqs_pkg::mem_req_t                mem_req,
  output logic signed [dqs_pkg::DATA_W-1:0]     rd_data
);

  logic signed [dqs_pkg::DATA_W-1:0] mem_r [dqs_pkg::DEPTH];
  logic signed [dqs_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem_r[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[mem_req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[hw/rtl/dqs_ctrl.sv]
// Sequencer: ring pointers, request decode and the search comparator.
`default_nettype none
module dqs_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire logic [dqs_pkg::REQ_W-1:0]        req_type,
  input  wire logic signed [dqs_pkg::DATA_W-1:0] req_value,
  output dqs_pkg::mem_req_t                     mem_req,
  input  wire logic signed [dqs_pkg::DATA_W-1:0] rd_data,
  output dqs_pkg::result_t                      result,
  input  wire logic                             res_free
);

  localparam int IDX_W  = dqs_pkg::IDX_W;
  localparam int CNT_W  = dqs_pkg::CNT_W;
  localparam int DATA_W = dqs_pkg::DATA_W;

  dqs_pkg::state_t  state_r, state_nxt;
  dqs_pkg::req_t    req_r, req_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             pend_r, pend_nxt;
  dqs_pkg::status_t res_status_r, res_status_nxt;
  logic signed [DATA_W-1:0] res_data_r, res_data_nxt;

  logic full, empty, issue, hit;

  assign full  = (fill_r == CNT_W'(dqs_pkg::DEPTH));
  assign empty = (fill_r == '0);
  assign issue = (scan_r < fill_r);
  assign hit   = pend_r && (rd_data == val_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqs_pkg::S_IDLE;
      front_r <= '0;
      fill_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    val_r        <= val_nxt;
    scan_r       <= scan_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    val_nxt        = val_r;
    front_nxt      = front_r;
    fill_nxt       = fill_r;
    scan_nxt       = scan_r;
    pend_nxt       = 1'b0;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    req_ready      = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = front_r;
    mem_req.wr_data = val_r;
    mem_req.rd_addr = front_r;
    result.valid    = 1'b0;
    result.status   = res_status_r;
    result.data     = res_data_r;
    result.count    = dqs_pkg::count_field(fill_r);

    case (state_r)
      dqs_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_nxt   = dqs_pkg::req_t'(req_type);
          val_nxt   = req_value;
          state_nxt = dqs_pkg::S_EXEC;
        end
      end

      dqs_pkg::S_EXEC: begin
        res_status_nxt = dqs_pkg::ST_OK;
        res_data_nxt   = '0;
        state_nxt      = dqs_pkg::S_EMIT;
        case (req_r)
          dqs_pkg::REQ_PUSH_FRONT: begin
            if (full) begin
              res_status_nxt = dqs_pkg::ST_FULL;
            end else begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = dqs_pkg::ring_dec(front_r);
              front_nxt       = dqs_pkg::ring_dec(front_r);
              fill_nxt        = fill_r + CNT_W'(1);
            end
          end
          dqs_pkg::REQ_PUSH_BACK: begin
            if (full) begin
              res_status_nxt = dqs_pkg::ST_FULL;
            end else begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = dqs_pkg::ring_add(front_r, fill_r);
              fill_nxt        = fill_r + CNT_W'(1);
            end
          end
          dqs_pkg::REQ_POP_FRONT: begin
            if (empty) begin
              res_status_nxt = dqs_pkg::ST_EMPTY;
            end else begin
              mem_req.rd_addr = front_r;
              front_nxt       = dqs_pkg::ring_add(front_r, CNT_W'(1));
              fill_nxt        = fill_r - CNT_W'(1);
              state_nxt       = dqs_pkg::S_POPWAIT;
            end
          end
          dqs_pkg::REQ_POP_BACK: begin
            if (empty) begin
              res_status_nxt = dqs_pkg::ST_EMPTY;
            end else begin
              mem_req.rd_addr = dqs_pkg::ring_add(front_r, fill_r - CNT_W'(1));
              fill_nxt        = fill_r - CNT_W'(1);
              state_nxt       = dqs_pkg::S_POPWAIT;
            end
          end
          dqs_pkg::REQ_SEARCH: begin
            res_data_nxt = val_r;
            if (empty) begin
              res_status_nxt = dqs_pkg::ST_EMPTY;
            end else begin
              scan_nxt  = '0;
              state_nxt = dqs_pkg::S_SEARCH;
            end
          end
          default: begin
          end
        endcase
      end

      dqs_pkg::S_POPWAIT: begin
        res_data_nxt = rd_data;
        state_nxt    = dqs_pkg::S_EMIT;
      end

      // read of entry i overlaps the compare of entry i-1
      dqs_pkg::S_SEARCH: begin
        mem_req.rd_addr = dqs_pkg::ring_add(front_r, scan_r);
        if (hit) begin
          res_status_nxt = dqs_pkg::ST_OK;
          state_nxt      = dqs_pkg::S_EMIT;
        end else if (!issue && !pend_r) begin
          res_status_nxt = dqs_pkg::ST_NOTFOUND;
          state_nxt      = dqs_pkg::S_EMIT;
        end else if (issue) begin
          scan_nxt = scan_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
      end

      dqs_pkg::S_EMIT: begin
        result.valid = 1'b1;
        if (res_free) begin
          state_nxt = dqs_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dqs_pkg::S_IDLE;
      end
    endcase
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(dqs_pkg::DEPTH))
    else $error("fill count above ring depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r < IDX_W'(dqs_pkg::DEPTH - 1) || front_r == IDX_W'(dqs_pkg::DEPTH - 1))
    else $error("front index outside ring");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && req_ready |=> state_r == dqs_pkg::S_EXEC)
    else $error("accepted word not executed");

  a_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> !full && state_r == dqs_pkg::S_EXEC)
    else $error("ring written while full or outside execute");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != dqs_pkg::S_EXEC |=> $stable(fill_r))
    else $error("fill count moved outside execute");

endmodule
`default_nettype wire

[hw/rtl/deque_with_search.sv]
// Top level of the deque with search: ring, sequencer and output register.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_ready, in_req_type, in_value
//   out     | output    | out_valid, out_ready, out_status, out_data, out_count
//
// Pushes and empty/full cases pass through execute and emit to the output register; pops add a wait state.
// A search reads one entry per cycle through the single ring read port and
// compares each entry in the following cycle, stopping early on a hit.
// in_ready is high only while the sequencer is idle; a waiting result in the
// output register does not block the next accept.
// Synchronous active-low reset empties the ring; stored words are not cleared.
`default_nettype none
module deque_with_search (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [dqs_pkg::REQ_W-1:0]          in_req_type,
  input  wire logic signed [dqs_pkg::DATA_W-1:0]  in_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [dqs_pkg::STATUS_W-1:0]            out_status,
  output logic signed [dqs_pkg::DATA_W-1:0]       out_data,
  output logic [dqs_pkg::COUNT_W-1:0]             out_count
);

  dqs_pkg::mem_req_t mem_req;
  dqs_pkg::result_t  result;
  logic signed [dqs_pkg::DATA_W-1:0] rd_data;
  logic res_free;

  logic                              out_valid_r;
  logic [dqs_pkg::STATUS_W-1:0]      out_status_r;
  logic signed [dqs_pkg::DATA_W-1:0] out_data_r;
  logic [dqs_pkg::COUNT_W-1:0]       out_count_r;

  dqs_ring u_ring (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  dqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req_type  (in_req_type),
    .req_value (in_value),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .result    (result),
    .res_free  (res_free)
  );

  assign res_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && result.valid) begin
      out_status_r <= result.status;
      out_data_r   <= result.data;
      out_count_r  <= result.count;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_count  = out_count_r;

endmodule
`default_nettype wire
